FILE: hdl/mbd_pkg.sv
// shared types, constants and the code table for the morse button decoder
package mbd_pkg;

  localparam int UNIT_W      = 16;
  localparam int DEB_W       = 4;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int CHAR_W      = 7;
  localparam int CODE_LEN_W  = 3;
  localparam int MAX_CODE_LEN = 5;
  localparam int NUM_CODES   = 36;
  localparam int NUM_LETTERS = 26;
  // widest threshold is seven units
  localparam int THR_W       = UNIT_W + 3;

  localparam logic [CFG_ADDR_W-1:0] REG_UNIT_TICKS       = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_SAMPLES = 1'b1;

  localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET       = 16'd100;
  localparam logic [DEB_W-1:0]  DEBOUNCE_SAMPLES_RESET = 4'd5;

  localparam logic [CHAR_W-1:0] CHAR_UNKNOWN = 7'h3F; // '?'
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20; // ' '
  localparam logic [CHAR_W-1:0] CHAR_A       = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;

  typedef struct packed {
    logic [CODE_LEN_W-1:0]   len;
    logic [MAX_CODE_LEN-1:0] pat;  // bit i set: symbol i is a dash
  } code_t;

  localparam code_t CODE_TABLE [NUM_CODES] = '{
    '{3'd2, 5'd2},  '{3'd4, 5'd1},  '{3'd4, 5'd5},  '{3'd3, 5'd1},
    '{3'd1, 5'd0},  '{3'd4, 5'd4},  '{3'd3, 5'd3},  '{3'd4, 5'd0},
    '{3'd2, 5'd0},  '{3'd4, 5'd14}, '{3'd3, 5'd5},  '{3'd4, 5'd2},
    '{3'd2, 5'd3},  '{3'd2, 5'd1},  '{3'd3, 5'd7},  '{3'd4, 5'd6},
    '{3'd4, 5'd11}, '{3'd3, 5'd2},  '{3'd3, 5'd0},  '{3'd1, 5'd1},
    '{3'd3, 5'd4},  '{3'd4, 5'd8},  '{3'd3, 5'd6},  '{3'd4, 5'd9},
    '{3'd4, 5'd13}, '{3'd4, 5'd3},
    '{3'd5, 5'd31}, '{3'd5, 5'd30}, '{3'd5, 5'd28}, '{3'd5, 5'd24},
    '{3'd5, 5'd16}, '{3'd5, 5'd0},  '{3'd5, 5'd1},  '{3'd5, 5'd3},
    '{3'd5, 5'd7},  '{3'd5, 5'd15}
  };

  // a length of zero never matches, so callers pass zero for codes that are too long
  function automatic logic [CHAR_W-1:0] decode_code(
    input logic [MAX_CODE_LEN-1:0] pat,
    input logic [CODE_LEN_W-1:0]   len
  );
    logic [CHAR_W-1:0] ch;
    ch = CHAR_UNKNOWN;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (CODE_TABLE[i].len == len && CODE_TABLE[i].pat == pat) begin
        if (i < NUM_LETTERS) begin
          ch = CHAR_A + CHAR_W'(i);
        end else begin
          ch = CHAR_ZERO + CHAR_W'(i - NUM_LETTERS);
        end
      end
    end
    return ch;
  endfunction

endpackage

FILE: hdl/morse_button_decoder.sv
// morse key decoder: debounce, press timing, symbol collection and character output
// One key sample is taken per clock and the block sustains one beat per cycle while the
// output queue is not full. A sample passes an input register, then a single pass of
// debounce, timer and decode logic updates the state and may push one character into a
// two-entry output queue, from which it is presented on the output. The input side stalls
// only while the output queue is full. Timers are TIMER_BITS wide and saturate; at most
// MAX_SYMBOLS symbols are kept per character. Thresholds are 2, 3 and 7 times unit_ticks.
module morse_button_decoder #(
  parameter int MAX_SYMBOLS = 9,
  parameter int TIMER_BITS  = 20
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // [0] key_level, [7:1] zero
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // [6:0] out_char, [7] zero
  input  logic                               cfg_we,
  input  logic [mbd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int CMP_W = (TIMER_BITS > mbd_pkg::THR_W) ? TIMER_BITS : mbd_pkg::THR_W;

  // configuration
  logic [mbd_pkg::UNIT_W-1:0] unit_ticks;
  logic [mbd_pkg::DEB_W-1:0]  debounce_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_ticks       <= mbd_pkg::UNIT_TICKS_RESET;
      debounce_samples <= mbd_pkg::DEBOUNCE_SAMPLES_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        mbd_pkg::REG_UNIT_TICKS:       unit_ticks       <= cfg_wdata;
        mbd_pkg::REG_DEBOUNCE_SAMPLES: debounce_samples <= cfg_wdata[mbd_pkg::DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic in_valid;
  logic in_sample;
  logic proc;
  logic [1:0] q_count;

  assign proc          = in_valid && (q_count != 2'd2);
  assign s_axis_tready = !in_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_sample <= s_axis_tdata[0];
    end
  end

  // decoder state
  logic                  last_level, last_level_next;
  logic [3:0]            same_count, same_count_next;
  logic                  stable_level, stable_level_next;
  logic [TIMER_BITS-1:0] press_timer, press_timer_next;
  logic [TIMER_BITS-1:0] release_timer, release_timer_next;
  logic                  started_flag, started_flag_next;
  logic                  letter_emitted, letter_emitted_next;
  logic                  space_emitted, space_emitted_next;
  logic [MAX_SYMBOLS-1:0] symbol_bits, symbol_bits_next;
  logic [CNT_W-1:0]      symbol_count, symbol_count_next;

  logic                         emit;
  logic [mbd_pkg::CHAR_W-1:0]   emit_char;
  logic [CMP_W-1:0]             thr_dash, thr_letter, thr_space;
  logic [CMP_W-1:0]             unit_ext;
  logic [TIMER_BITS-1:0]        press_inc;
  logic [mbd_pkg::CODE_LEN_W-1:0] code_len;

  assign unit_ext   = CMP_W'(unit_ticks);
  assign thr_dash   = unit_ext << 1;
  assign thr_letter = (unit_ext << 1) + unit_ext;
  assign thr_space  = (unit_ext << 3) - unit_ext;

  always_comb begin
    last_level_next     = last_level;
    same_count_next     = same_count;
    stable_level_next   = stable_level;
    press_timer_next    = press_timer;
    release_timer_next  = release_timer;
    started_flag_next   = started_flag;
    letter_emitted_next = letter_emitted;
    space_emitted_next  = space_emitted;
    symbol_bits_next    = symbol_bits;
    symbol_count_next   = symbol_count;
    emit                = 1'b0;
    emit_char           = mbd_pkg::CHAR_SPACE;
    code_len            = '0;

    // saturating timer of the current stable level
    press_inc = (press_timer == '1) ? press_timer : press_timer + 1'b1;
    if (!stable_level) begin
      press_timer_next = press_inc;
    end else if (release_timer != '1) begin
      release_timer_next = release_timer + 1'b1;
    end

    // debounce
    if (in_sample == last_level) begin
      if (same_count != 4'hF) begin
        same_count_next = same_count + 1'b1;
      end
    end else begin
      last_level_next = in_sample;
      same_count_next = 4'd1;
    end

    if (same_count_next >= debounce_samples && stable_level != last_level_next) begin
      stable_level_next = last_level_next;
      if (!last_level_next) begin
        press_timer_next    = '0;
        letter_emitted_next = 1'b0;
        space_emitted_next  = 1'b0;
      end else begin
        if (symbol_count < CNT_W'(MAX_SYMBOLS) &&
            (CMP_W'(press_timer_next) >= thr_dash || press_timer_next != '0)) begin
          if (CMP_W'(press_timer_next) >= thr_dash) begin
            symbol_bits_next = symbol_bits | (MAX_SYMBOLS'(1) << symbol_count);
          end
          symbol_count_next = symbol_count + 1'b1;
        end
        release_timer_next = '0;
        started_flag_next  = 1'b1;
      end
    end

    // gap check
    if (started_flag_next && stable_level_next) begin
      if (!letter_emitted_next) begin
        if (CMP_W'(release_timer_next) >= thr_letter && symbol_count_next != '0) begin
          // codes longer than the table keep a length of zero
          if (symbol_count_next <= CNT_W'(mbd_pkg::MAX_CODE_LEN)) begin
            code_len = symbol_count_next[mbd_pkg::CODE_LEN_W-1:0];
          end
          emit                = 1'b1;
          emit_char           = mbd_pkg::decode_code(
                                  symbol_bits_next[mbd_pkg::MAX_CODE_LEN-1:0], code_len);
          symbol_bits_next    = '0;
          symbol_count_next   = '0;
          letter_emitted_next = 1'b1;
        end
      end else if (!space_emitted_next && CMP_W'(release_timer_next) >= thr_space) begin
        emit               = 1'b1;
        emit_char          = mbd_pkg::CHAR_SPACE;
        space_emitted_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_level     <= 1'b1;
      same_count     <= 4'd1;
      stable_level   <= 1'b1;
      press_timer    <= '0;
      release_timer  <= '0;
      started_flag   <= 1'b0;
      letter_emitted <= 1'b0;
      space_emitted  <= 1'b0;
      symbol_bits    <= '0;
      symbol_count   <= '0;
    end else if (proc) begin
      last_level     <= last_level_next;
      same_count     <= same_count_next;
      stable_level   <= stable_level_next;
      press_timer    <= press_timer_next;
      release_timer  <= release_timer_next;
      started_flag   <= started_flag_next;
      letter_emitted <= letter_emitted_next;
      space_emitted  <= space_emitted_next;
      symbol_bits    <= symbol_bits_next;
      symbol_count   <= symbol_count_next;
    end
  end

  // two-entry output queue
  logic [mbd_pkg::CHAR_W-1:0] q_data [2];
  logic q_wr_ptr;
  logic q_rd_ptr;
  logic push;
  logic pop;

  assign push = proc && emit;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count  <= 2'd0;
      q_wr_ptr <= 1'b0;
      q_rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        q_wr_ptr <= ~q_wr_ptr;
      end
      if (pop) begin
        q_rd_ptr <= ~q_rd_ptr;
      end
      case ({push, pop})
        2'b10:   q_count <= q_count + 2'd1;
        2'b01:   q_count <= q_count - 2'd1;
        default: q_count <= q_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[q_wr_ptr] <= emit_char;
    end
  end

  assign m_axis_tvalid = (q_count != 2'd0);
  assign m_axis_tdata  = {1'b0, q_data[q_rd_ptr]};

endmodule
